### sv/mandelbrot_escape_time_lanes_top_defines.svh
// Assertion macros for the Mandelbrot escape-time block checker.
`ifndef MANDELBROT_ESCAPE_TIME_LANES_TOP_DEFINES_SVH
`define MANDELBROT_ESCAPE_TIME_LANES_TOP_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define MBET_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define MBET_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/mbet_pkg.sv
// Shared constants, types and functions of the Mandelbrot escape-time block.
`timescale 1ns / 1ps

package mbet_pkg;

  localparam int unsigned LANES_DEF       = 8;
  localparam int unsigned MAX_ITER_DEF    = 256;
  localparam int unsigned IMAGE_WIDTH_DEF = 800;

  localparam int unsigned FRAC_BITS   = 28;
  localparam int unsigned COORD_W     = 32;
  localparam int unsigned STEP_W      = 31;
  localparam int unsigned COL_W       = 10;
  localparam int unsigned ROW_W       = 10;
  localparam int unsigned CALC_W      = 13;
  localparam int unsigned COUNT_OUT_W = 9;
  localparam int unsigned COLOR_W     = 8;
  localparam int unsigned WIDE_W      = 48;
  localparam int unsigned SQ_W        = 2 * COORD_W;
  // |z|^2 >= 4.0 in Q8.56
  localparam int unsigned ESCAPE_BIT  = 2 * FRAC_BITS + 2;

  localparam logic [COLOR_W-1:0] RED_MUL   = 8'd197;
  localparam logic [COLOR_W-1:0] GREEN_MUL = 8'd237;
  localparam logic [COLOR_W-1:0] BLUE_MUL  = 8'hFF;

  localparam int unsigned ADDR_W = 4;
  localparam logic [1:0] REG_VIEW_X_MIN = 2'd0;
  localparam logic [1:0] REG_VIEW_Y_MIN = 2'd1;
  localparam logic [1:0] REG_STEP_X     = 2'd2;
  localparam logic [1:0] REG_STEP_Y     = 2'd3;

  localparam logic signed [COORD_W-1:0] VIEW_X_MIN_RST = -32'sd671088640;
  localparam logic signed [COORD_W-1:0] VIEW_Y_MIN_RST = -32'sd402653184;
  localparam logic [STEP_W-1:0]         STEP_RST       = 31'd1342177;

  typedef struct packed {
    logic c_mul;
    logic c_add;
    logic sq_mul;
    logic orbit_upd;
  } lane_ctrl_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } rgb_t;

  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = 48'sh0000_7FFF_FFFF;
    lo = 48'shFFFF_8000_0000;
    if (v > hi) begin
      return 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      return 32'sh8000_0000;
    end
    return v[COORD_W-1:0];
  endfunction

  function automatic rgb_t palette(input logic [COLOR_W-1:0] cnt);
    logic [2*COLOR_W-1:0] pr;
    logic [2*COLOR_W-1:0] pg;
    logic [2*COLOR_W-1:0] pb;
    rgb_t c;
    pr = (2*COLOR_W)'(cnt) * (2*COLOR_W)'(RED_MUL);
    pg = (2*COLOR_W)'(cnt) * (2*COLOR_W)'(GREEN_MUL);
    pb = (2*COLOR_W)'(cnt) * (2*COLOR_W)'(BLUE_MUL);
    c.red   = pr[COLOR_W-1:0];
    c.green = pg[COLOR_W-1:0];
    c.blue  = pb[COLOR_W-1:0];
    return c;
  endfunction

endpackage

### sv/mbet_lane.sv
// One pixel lane: maps its column to c and iterates z = z*z + c.
`timescale 1ns / 1ps

module mbet_lane #(
  parameter int unsigned LANE_ID        = 0,
  parameter int unsigned IMAGE_WIDTH    = mbet_pkg::IMAGE_WIDTH_DEF,
  parameter int unsigned MAX_ITERATIONS = mbet_pkg::MAX_ITER_DEF,
  localparam int unsigned CNT_W         = $clog2(MAX_ITERATIONS + 1)
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  mbet_pkg::lane_ctrl_t                  ctrl_i,
  input  logic [mbet_pkg::COL_W-1:0]            first_i,
  input  logic signed [mbet_pkg::COORD_W-1:0]   view_x_min_i,
  input  logic [mbet_pkg::STEP_W-1:0]           step_x_i,
  input  logic signed [mbet_pkg::COORD_W-1:0]   cy_i,
  input  logic [CNT_W-1:0]                      iter_i,
  output logic                                  active_o,
  output logic [CNT_W-1:0]                      esc_count_o
);

  localparam int unsigned CALC_W = mbet_pkg::CALC_W;
  localparam int unsigned PROD_W = mbet_pkg::CALC_W + mbet_pkg::STEP_W;
  localparam int unsigned WIDE_W = mbet_pkg::WIDE_W;
  localparam int unsigned SQ_W   = mbet_pkg::SQ_W;
  localparam int unsigned FB     = mbet_pkg::FRAC_BITS;

  logic [CALC_W-1:0] col_sum;
  logic [CALC_W-1:0] col_calc;
  logic [PROD_W-1:0] prod_d, prod_q;
  logic signed [WIDE_W-1:0] cx_wide;
  logic signed [mbet_pkg::COORD_W-1:0] cx_q;
  logic signed [mbet_pkg::COORD_W-1:0] x_d, x_q, y_d, y_q;
  logic signed [SQ_W-1:0] x2_q, y2_q, xy_q;
  logic [SQ_W-1:0] mag;
  logic escape;
  logic signed [SQ_W-1:0] diff;
  logic signed [SQ_W-FB-1:0] re_sh;
  logic signed [SQ_W-FB:0] im_sh;
  logic signed [WIDE_W-1:0] re_wide, im_wide;
  logic active_d, active_q;
  logic [CNT_W-1:0] esc_d, esc_q;

  assign col_sum  = CALC_W'(first_i) + CALC_W'(LANE_ID);
  assign col_calc = (col_sum >= CALC_W'(IMAGE_WIDTH)) ? CALC_W'(IMAGE_WIDTH - 1) : col_sum;
  assign prod_d   = PROD_W'(col_calc) * PROD_W'(step_x_i);
  assign cx_wide  = WIDE_W'(view_x_min_i) + $signed(WIDE_W'(prod_q));

  assign mag    = x2_q + y2_q;
  assign escape = |mag[SQ_W-1:mbet_pkg::ESCAPE_BIT];
  assign diff   = x2_q - y2_q;
  assign re_sh  = diff[SQ_W-1:FB];
  assign im_sh  = xy_q[SQ_W-1:FB-1];
  assign re_wide = WIDE_W'(re_sh) + WIDE_W'(cx_q);
  assign im_wide = WIDE_W'(im_sh) + WIDE_W'(cy_i);

  always_comb begin
    x_d      = x_q;
    y_d      = y_q;
    active_d = active_q;
    esc_d    = esc_q;
    if (ctrl_i.c_add) begin
      x_d      = '0;
      y_d      = '0;
      active_d = 1'b1;
      esc_d    = CNT_W'(MAX_ITERATIONS);
    end else if (ctrl_i.orbit_upd && active_q) begin
      if (escape) begin
        active_d = 1'b0;
        esc_d    = iter_i;
      end else begin
        x_d = mbet_pkg::sat32(re_wide);
        y_d = mbet_pkg::sat32(im_wide);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else begin
      active_q <= active_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    esc_q <= esc_d;
    if (ctrl_i.c_mul) begin
      prod_q <= prod_d;
    end
    if (ctrl_i.c_add) begin
      cx_q <= mbet_pkg::sat32(cx_wide);
    end
    if (ctrl_i.sq_mul) begin
      x2_q <= SQ_W'(x_q) * SQ_W'(x_q);
      y2_q <= SQ_W'(y_q) * SQ_W'(y_q);
      xy_q <= SQ_W'(x_q) * SQ_W'(y_q);
    end
  end

  assign active_o    = active_q;
  assign esc_count_o = esc_q;

endmodule

### sv/mbet_merge.sv
// Merging stage: walks the lanes in order and emits one result item per pixel.
`timescale 1ns / 1ps

module mbet_merge #(
  parameter int unsigned LANES          = mbet_pkg::LANES_DEF,
  parameter int unsigned MAX_ITERATIONS = mbet_pkg::MAX_ITER_DEF,
  localparam int unsigned LANE_W        = (LANES > 1) ? $clog2(LANES) : 1,
  localparam int unsigned NUM_W         = $clog2(LANES + 1),
  localparam int unsigned CNT_W         = $clog2(MAX_ITERATIONS + 1)
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic [NUM_W-1:0]                      count_i,
  input  logic [mbet_pkg::COL_W-1:0]            first_i,
  input  logic [LANES-1:0][CNT_W-1:0]           esc_i,
  input  logic                                  stall_i,
  output logic                                  busy_o,
  output logic                                  valid_o,
  output logic [mbet_pkg::COL_W-1:0]            pixel_column_o,
  output logic [mbet_pkg::COUNT_OUT_W-1:0]      escape_count_o,
  output logic [mbet_pkg::COLOR_W-1:0]          red_o,
  output logic [mbet_pkg::COLOR_W-1:0]          green_o,
  output logic [mbet_pkg::COLOR_W-1:0]          blue_o,
  output logic                                  last_of_group_o
);

  localparam int unsigned CALC_W = mbet_pkg::CALC_W;
  localparam int unsigned EXT_W  = CNT_W + mbet_pkg::COUNT_OUT_W;

  logic busy_d, busy_q;
  logic valid_d, valid_q;
  logic [LANE_W-1:0] idx_d, idx_q;
  logic [NUM_W-1:0] num_q;
  logic load;
  logic is_last;
  logic [CNT_W-1:0] cnt_sel;
  logic [EXT_W-1:0] cnt_ext;
  logic black;
  mbet_pkg::rgb_t rgb;
  logic [CALC_W-1:0] col_sum;

  logic [mbet_pkg::COL_W-1:0]       col_q;
  logic [mbet_pkg::COUNT_OUT_W-1:0] cnt_q;
  mbet_pkg::rgb_t                   rgb_q;
  logic                             last_q;

  assign load    = busy_q && (!valid_q || !stall_i);
  assign is_last = (NUM_W'(idx_q) + NUM_W'(1)) == num_q;
  assign cnt_sel = esc_i[idx_q];
  assign cnt_ext = EXT_W'(cnt_sel);
  assign black   = cnt_sel == CNT_W'(MAX_ITERATIONS);
  assign rgb     = black ? '0 : mbet_pkg::palette(cnt_ext[mbet_pkg::COLOR_W-1:0]);
  assign col_sum = CALC_W'(first_i) + CALC_W'(idx_q);

  always_comb begin
    busy_d  = busy_q;
    idx_d   = idx_q;
    valid_d = valid_q && stall_i;
    if (start_i) begin
      busy_d = count_i != '0;
      idx_d  = '0;
    end else if (load) begin
      valid_d = 1'b1;
      idx_d   = idx_q + LANE_W'(1);
      if (is_last) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      busy_q  <= busy_d;
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= count_i;
    end
    if (load && !start_i) begin
      col_q  <= col_sum[mbet_pkg::COL_W-1:0];
      cnt_q  <= cnt_ext[mbet_pkg::COUNT_OUT_W-1:0];
      rgb_q  <= rgb;
      last_q <= is_last;
    end
  end

  assign busy_o          = busy_q;
  assign valid_o         = valid_q;
  assign pixel_column_o  = col_q;
  assign escape_count_o  = cnt_q;
  assign red_o           = rgb_q.red;
  assign green_o         = rgb_q.green;
  assign blue_o          = rgb_q.blue;
  assign last_of_group_o = last_q;

endmodule

### sv/mandelbrot_escape_time_lanes_top.sv
// Top level of the Mandelbrot escape-time block with parallel pixel lanes.
//
// Input channel (valid_i / stall_o): one item names an image row and the first
// column of a group of LANES pixels. Output channel (valid_o / stall_i): one
// item per pixel of the group that lies inside the image, in column order,
// last_of_group_o set on the final one; a group starting past the edge gives none.
// Config: APB registers view_x_min, view_y_min, step_x, step_y at 0x0..0xC, to be
// written only while the block is idle; the block itself does not enforce this.
// Sequence: form c (S_CMUL, S_CADD), then per iteration a square multiply
// (S_MUL), then escape test and orbit update (S_UPD) in every lane at once, for up
// to MAX_ITERATIONS iterations or until all lanes have escaped (checked in S_MUL),
// then one result per cycle while stall_i is low; the dependent orbit loop through
// the lane multipliers sets the worst-case time per item.
// One item is in work at a time; stall_o stays high until the last result of the
// group sits in the output register, which holds while stall_i is high.
// Reset clears the control state and returns the registers to their defaults.
`timescale 1ns / 1ps

module mandelbrot_escape_time_lanes_top #(
  parameter int unsigned LANES          = mbet_pkg::LANES_DEF,
  parameter int unsigned MAX_ITERATIONS = mbet_pkg::MAX_ITER_DEF,
  parameter int unsigned IMAGE_WIDTH    = mbet_pkg::IMAGE_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mbet_pkg::ADDR_W-1:0]       paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  input  logic                              valid_i,
  output logic                              stall_o,
  input  logic [mbet_pkg::COL_W-1:0]        group_column_i,
  input  logic [mbet_pkg::ROW_W-1:0]        row_index_i,
  output logic                              valid_o,
  input  logic                              stall_i,
  output logic [mbet_pkg::COL_W-1:0]        pixel_column_o,
  output logic [mbet_pkg::COUNT_OUT_W-1:0]  escape_count_o,
  output logic [mbet_pkg::COLOR_W-1:0]      red_o,
  output logic [mbet_pkg::COLOR_W-1:0]      green_o,
  output logic [mbet_pkg::COLOR_W-1:0]      blue_o,
  output logic                              last_of_group_o
);

  localparam int unsigned CNT_W  = $clog2(MAX_ITERATIONS + 1);
  localparam int unsigned NUM_W  = $clog2(LANES + 1);
  localparam int unsigned CALC_W = mbet_pkg::CALC_W;
  localparam int unsigned YP_W   = mbet_pkg::ROW_W + mbet_pkg::STEP_W;
  localparam int unsigned WIDE_W = mbet_pkg::WIDE_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CMUL = 3'd1;
  localparam logic [2:0] S_CADD = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic signed [mbet_pkg::COORD_W-1:0] view_x_q, view_y_q;
  logic [mbet_pkg::STEP_W-1:0] step_x_q, step_y_q;
  logic cfg_wr;
  logic [1:0] cfg_idx;

  logic [2:0] state_d, state_q;
  logic [CNT_W-1:0] iter_d, iter_q;
  logic [mbet_pkg::COL_W-1:0] first_q;
  logic [mbet_pkg::ROW_W-1:0] row_q;
  logic [YP_W-1:0] cy_prod_q;
  logic signed [WIDE_W-1:0] cy_wide;
  logic signed [mbet_pkg::COORD_W-1:0] cy_q;
  logic [CALC_W-1:0] first_ext;
  logic [CALC_W-1:0] rem;
  logic [NUM_W-1:0] num_d, num_q;
  logic accept;
  logic merge_start;
  logic merge_busy;
  mbet_pkg::lane_ctrl_t lane_ctrl;
  logic [LANES-1:0] active;
  logic [LANES-1:0][CNT_W-1:0] esc;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      view_x_q <= mbet_pkg::VIEW_X_MIN_RST;
      view_y_q <= mbet_pkg::VIEW_Y_MIN_RST;
      step_x_q <= mbet_pkg::STEP_RST;
      step_y_q <= mbet_pkg::STEP_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        mbet_pkg::REG_VIEW_X_MIN: view_x_q <= pwdata;
        mbet_pkg::REG_VIEW_Y_MIN: view_y_q <= pwdata;
        mbet_pkg::REG_STEP_X:     step_x_q <= pwdata[mbet_pkg::STEP_W-1:0];
        mbet_pkg::REG_STEP_Y:     step_y_q <= pwdata[mbet_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      mbet_pkg::REG_VIEW_X_MIN: prdata = view_x_q;
      mbet_pkg::REG_VIEW_Y_MIN: prdata = view_y_q;
      mbet_pkg::REG_STEP_X:     prdata = {1'b0, step_x_q};
      mbet_pkg::REG_STEP_Y:     prdata = {1'b0, step_y_q};
      default:                  prdata = '0;
    endcase
  end

  // sequencer
  assign accept  = valid_i && (state_q == S_IDLE);
  assign stall_o = state_q != S_IDLE;

  assign first_ext = CALC_W'(first_q);
  assign rem       = CALC_W'(IMAGE_WIDTH) - first_ext;
  assign cy_wide   = WIDE_W'(view_y_q) + $signed(WIDE_W'(cy_prod_q));

  always_comb begin
    if (first_ext >= CALC_W'(IMAGE_WIDTH)) begin
      num_d = '0;
    end else if (rem >= CALC_W'(LANES)) begin
      num_d = NUM_W'(LANES);
    end else begin
      num_d = rem[NUM_W-1:0];
    end
  end

  always_comb begin
    state_d     = state_q;
    iter_d      = iter_q;
    merge_start = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_CMUL;
        end
      end
      S_CMUL: state_d = S_CADD;
      S_CADD: begin
        iter_d  = '0;
        state_d = S_MUL;
      end
      S_MUL: begin
        if (active == '0) begin
          merge_start = 1'b1;
          state_d     = S_EMIT;
        end else begin
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        if (iter_q == CNT_W'(MAX_ITERATIONS - 1)) begin
          merge_start = 1'b1;
          state_d     = S_EMIT;
        end else begin
          iter_d  = iter_q + CNT_W'(1);
          state_d = S_MUL;
        end
      end
      S_EMIT: begin
        if (!merge_busy) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      iter_q  <= '0;
    end else begin
      state_q <= state_d;
      iter_q  <= iter_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      first_q <= group_column_i;
      row_q   <= row_index_i;
    end
    if (state_q == S_CMUL) begin
      cy_prod_q <= YP_W'(row_q) * YP_W'(step_y_q);
      num_q     <= num_d;
    end
    if (state_q == S_CADD) begin
      cy_q <= mbet_pkg::sat32(cy_wide);
    end
  end

  assign lane_ctrl.c_mul     = state_q == S_CMUL;
  assign lane_ctrl.c_add     = state_q == S_CADD;
  assign lane_ctrl.sq_mul    = state_q == S_MUL;
  assign lane_ctrl.orbit_upd = state_q == S_UPD;

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    mbet_lane #(
      .LANE_ID        (l),
      .IMAGE_WIDTH    (IMAGE_WIDTH),
      .MAX_ITERATIONS (MAX_ITERATIONS)
    ) u_lane (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (lane_ctrl),
      .first_i      (first_q),
      .view_x_min_i (view_x_q),
      .step_x_i     (step_x_q),
      .cy_i         (cy_q),
      .iter_i       (iter_q),
      .active_o     (active[l]),
      .esc_count_o  (esc[l])
    );
  end

  mbet_merge #(
    .LANES          (LANES),
    .MAX_ITERATIONS (MAX_ITERATIONS)
  ) u_merge (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (merge_start),
    .count_i         (num_q),
    .first_i         (first_q),
    .esc_i           (esc),
    .stall_i         (stall_i),
    .busy_o          (merge_busy),
    .valid_o         (valid_o),
    .pixel_column_o  (pixel_column_o),
    .escape_count_o  (escape_count_o),
    .red_o           (red_o),
    .green_o         (green_o),
    .blue_o          (blue_o),
    .last_of_group_o (last_of_group_o)
  );

endmodule

### sv/mbet_checker.sv
// Port-level checker for the Mandelbrot escape-time block, bound to the top level.
`timescale 1ns / 1ps
`include "mandelbrot_escape_time_lanes_top_defines.svh"

module mbet_checker #(
  parameter int unsigned IMAGE_WIDTH = mbet_pkg::IMAGE_WIDTH_DEF
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              valid_i,
  input logic                              stall_o,
  input logic                              valid_o,
  input logic                              stall_i,
  input logic [mbet_pkg::COL_W-1:0]        pixel_column_o,
  input logic [mbet_pkg::COUNT_OUT_W-1:0]  escape_count_o,
  input logic [mbet_pkg::COLOR_W-1:0]      red_o,
  input logic [mbet_pkg::COLOR_W-1:0]      green_o,
  input logic [mbet_pkg::COLOR_W-1:0]      blue_o,
  input logic                              last_of_group_o
);

  `MBET_ASSERT_NEXT(a_out_hold, valid_o && stall_i, valid_o && $stable(pixel_column_o) && $stable(escape_count_o) && $stable(red_o) && $stable(green_o) && $stable(blue_o) && $stable(last_of_group_o), "stalled result item changed")

  `MBET_ASSERT_NEXT(a_busy_after_accept, valid_i && !stall_o, stall_o, "input not stalled after an accepted item")

  `MBET_ASSERT_IMPL(a_column_in_image, valid_o, pixel_column_o < IMAGE_WIDTH, "result column outside the image")

  `MBET_ASSERT_IMPL(a_blue_matches_count, valid_o && (blue_o != 8'd0), blue_o == (8'd0 - escape_count_o[7:0]), "blue channel does not match escape count")

endmodule

bind mandelbrot_escape_time_lanes_top mbet_checker #(
  .IMAGE_WIDTH (IMAGE_WIDTH)
) u_mbet_checker (.*);

### dv/tb_top.sv
// Self-checking testbench for the Mandelbrot escape-time lanes block.
`timescale 1ns / 1ps

module tb_top;

  import mbet_pkg::*;

  localparam int unsigned NLANES   = LANES_DEF;
  localparam int unsigned ITER_MAX = MAX_ITER_DEF;
  localparam int unsigned IMAGE_W  = IMAGE_WIDTH_DEF;
  // worst case per group: every iteration, c setup, emit
  localparam int unsigned SETTLE_CYCLES = 2 * ITER_MAX + NLANES + 80;
  localparam int unsigned QUIET_LIMIT   = 20000;
  localparam int unsigned HOLD_CYCLES   = 3000;
  localparam int unsigned DIR_N         = 19;
  localparam int unsigned VIEW_N        = 6;
  localparam logic [63:0] ESCAPE_MAG    = 64'd4 << (2 * FRAC_BITS);

  typedef struct packed {
    logic [COL_W-1:0]       column;
    logic [COUNT_OUT_W-1:0] count;
    logic [COLOR_W-1:0]     red;
    logic [COLOR_W-1:0]     green;
    logic [COLOR_W-1:0]     blue;
    logic                   last;
  } pixel_t;

  typedef struct packed {
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] sx;
    logic [31:0] sy;
  } view_t;

  typedef struct packed {
    logic [2:0]             view;
    logic [COL_W-1:0]       col;
    logic [ROW_W-1:0]       row;
    logic                   typed;
    logic [COUNT_OUT_W-1:0] cnt;
    logic [COLOR_W-1:0]     red;
    logic [COLOR_W-1:0]     green;
    logic [COLOR_W-1:0]     blue;
  } dir_row_t;

  logic                   clk_i;
  logic                   rst_ni         = 1'b0;
  logic                   psel           = 1'b0;
  logic                   penable        = 1'b0;
  logic                   pwrite         = 1'b0;
  logic [ADDR_W-1:0]      paddr          = '0;
  logic [31:0]            pwdata         = '0;
  logic [31:0]            prdata;
  logic                   pready;
  logic                   valid_i        = 1'b0;
  logic                   stall_o;
  logic [COL_W-1:0]       group_column_i = '0;
  logic [ROW_W-1:0]       row_index_i    = '0;
  logic                   valid_o;
  logic                   stall_i        = 1'b0;
  logic [COL_W-1:0]       pixel_column_o;
  logic [COUNT_OUT_W-1:0] escape_count_o;
  logic [COLOR_W-1:0]     red_o;
  logic [COLOR_W-1:0]     green_o;
  logic [COLOR_W-1:0]     blue_o;
  logic                   last_of_group_o;

  // predictor copy of registers and lane state
  logic signed [COORD_W-1:0] pred_vx = VIEW_X_MIN_RST;
  logic signed [COORD_W-1:0] pred_vy = VIEW_Y_MIN_RST;
  logic [STEP_W-1:0]         pred_sx = STEP_RST;
  logic [STEP_W-1:0]         pred_sy = STEP_RST;
  logic signed [COORD_W-1:0] orb_re   [NLANES];
  logic signed [COORD_W-1:0] orb_im   [NLANES];
  logic [COUNT_OUT_W-1:0]    lane_cnt [NLANES];
  logic [NLANES-1:0]         lane_busy;
  int unsigned               iter_run;

  pixel_t      pixel_expect_q [$];
  int unsigned err_cnt        = 0;
  int unsigned groups_sent    = 0;
  int unsigned pixels_checked = 0;
  int unsigned views_used     = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned idle_pct       = 0;
  int unsigned stall_pct      = 0;
  int unsigned hold_req       = 0;
  int unsigned hold_left      = 0;

  dir_row_t dir_tab  [DIR_N];
  view_t    view_tab [VIEW_N];

  mandelbrot_escape_time_lanes_top i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .valid_i         (valid_i),
    .stall_o         (stall_o),
    .group_column_i  (group_column_i),
    .row_index_i     (row_index_i),
    .valid_o         (valid_o),
    .stall_i         (stall_i),
    .pixel_column_o  (pixel_column_o),
    .escape_count_o  (escape_count_o),
    .red_o           (red_o),
    .green_o         (green_o),
    .blue_o          (blue_o),
    .last_of_group_o (last_of_group_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic signed [COORD_W-1:0] clamp_q428(input longint v);
    if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) return 32'sh8000_0000;
    return v[COORD_W-1:0];
  endfunction

  // escape-time iteration of one group, queues one pixel per in-image column
  function automatic void predict_group(input logic [COL_W-1:0] first,
                                        input logic [ROW_W-1:0] row);
    longint       ci, x, y, x2, y2, xy;
    longint       cx [NLANES];
    logic [63:0]  mag;
    int unsigned  col, l;
    pixel_t       px;
    ci = clamp_q428(longint'(pred_vy) + longint'(row) * longint'(pred_sy));
    for (l = 0; l < NLANES; l++) begin
      col = first + l;
      if (col >= IMAGE_W) col = IMAGE_W - 1;
      cx[l] = clamp_q428(longint'(pred_vx) + longint'(col) * longint'(pred_sx));
      orb_re[l] = '0;
      orb_im[l] = '0;
      lane_cnt[l] = COUNT_OUT_W'(ITER_MAX);
    end
    lane_busy = '1;
    for (iter_run = 0; iter_run < ITER_MAX && lane_busy != 0; iter_run++) begin
      for (l = 0; l < NLANES; l++) begin
        if (lane_busy[l]) begin
          x = orb_re[l];
          y = orb_im[l];
          x2 = x * x;
          y2 = y * y;
          mag = 64'(x2) + 64'(y2);
          if (mag >= ESCAPE_MAG) begin
            lane_busy[l] = 1'b0;
            lane_cnt[l] = COUNT_OUT_W'(iter_run);
          end else begin
            xy = x * y;
            orb_re[l] = clamp_q428(((x2 - y2) >>> FRAC_BITS) + cx[l]);
            orb_im[l] = clamp_q428((xy >>> (FRAC_BITS - 1)) + ci);
          end
        end
      end
    end
    for (l = 0; l < NLANES; l++) begin
      col = first + l;
      if (col < IMAGE_W) begin
        px.column = COL_W'(col);
        px.count  = lane_cnt[l];
        if (lane_cnt[l] == ITER_MAX) begin
          px.red   = '0;
          px.green = '0;
          px.blue  = '0;
        end else begin
          px.red   = COLOR_W'(lane_cnt[l] * RED_MUL);
          px.green = COLOR_W'(lane_cnt[l] * GREEN_MUL);
          px.blue  = COLOR_W'(lane_cnt[l] * BLUE_MUL);
        end
        px.last = (col == IMAGE_W - 1) || (l == NLANES - 1);
        pixel_expect_q.push_back(px);
      end
    end
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endfunction

  task automatic offer_group(input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row);
    while ($urandom_range(0, 99) < idle_pct) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i        <= 1'b1;
    group_column_i <= col;
    row_index_i    <= row;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
    groups_sent++;
  endtask

  // stop sending, wait for all pixels, then let a no-result group finish too
  task automatic settle_block();
    valid_i <= 1'b0;
    @(posedge clk_i);
    while (pixel_expect_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      REG_VIEW_X_MIN: pred_vx = data;
      REG_VIEW_Y_MIN: pred_vy = data;
      REG_STEP_X:     pred_sx = data[STEP_W-1:0];
      REG_STEP_Y:     pred_sy = data[STEP_W-1:0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_view(input view_t vw);
    apb_write(REG_VIEW_X_MIN, vw.vx);
    apb_write(REG_VIEW_Y_MIN, vw.vy);
    apb_write(REG_STEP_X, vw.sx);
    apb_write(REG_STEP_Y, vw.sy);
    views_used++;
  endtask

  // receiver: random stall, plus a counted hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_left == 0 && hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left != 0) begin
        stall_i <= 1'b1;
        hold_left--;
      end else begin
        stall_i <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    pixel_t px;
    if (rst_ni && valid_o && !stall_i) begin
      if (pixel_expect_q.size() == 0) begin
        $error("unexpected pixel item, column %0d", pixel_column_o);
        err_cnt++;
      end else begin
        px = pixel_expect_q.pop_front();
        check_field("pixel_column", px.column, pixel_column_o);
        check_field("escape_count", px.count, escape_count_o);
        check_field("red", px.red, red_o);
        check_field("green", px.green, green_o);
        check_field("blue", px.blue, blue_o);
        check_field("last_of_group", px.last, last_of_group_o);
        pixels_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((valid_i && !stall_o) || (valid_o && !stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", QUIET_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int unsigned   cur_view;
    int unsigned   ph;
    int unsigned   k;
    int unsigned   n;
    int unsigned   l;
    int unsigned   col;
    int unsigned   sh;
    view_t         vw;
    pixel_t        px;
    logic [COL_W-1:0] rc;
    logic [ROW_W-1:0] rr;
    int unsigned   idle_tab  [4];
    int unsigned   stall_tab [4];

    idle_tab  = '{0, 79, 0, 23};
    stall_tab = '{0, 0, 79, 23};

    view_tab = '{
      '{32'hD800_0000, 32'hE800_0000, 32'd1342177,   32'd1342177},
      '{32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
      '{32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
      '{32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 32'h8000_0000},
      '{32'hE000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
      '{32'hE000_0001, 32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF}
    };

    // reset view, then c far out (escape count 1), extreme steps,
    // c at the origin (never escapes), c exactly on and just inside -2
    dir_tab = '{
      '{3'd0, 10'd0,    10'd0,    1'b0, 9'd0,   8'd0,   8'd0,   8'd0},
      '{3'd0, 10'd792,  10'd599,  1'b0, 9'd0,   8'd0,   8'd0,   8'd0},
      '{3'd0, 10'd797,  10'd300,  1'b0, 9'd0,   8'd0,   8'd0,   8'd0},
      '{3'd0, 10'd3,    10'd5,    1'b0, 9'd0,   8'd0,   8'd0,   8'd0},
      '{3'd0, 10'd400,  10'd1023, 1'b0, 9'd0,   8'd0,   8'd0,   8'd0},
      '{3'd0, 10'd520,  10'd300,  1'b0, 9'd0,   8'd0,   8'd0,   8'd0},
      '{3'd0, 10'd800,  10'd0,    1'b1, 9'd0,   8'd0,   8'd0,   8'd0},
      '{3'd0, 10'd1023, 10'd1023, 1'b1, 9'd0,   8'd0,   8'd0,   8'd0},
      '{3'd1, 10'd0,    10'd0,    1'b1, 9'd1,   8'd197, 8'd237, 8'd255},
      '{3'd1, 10'd792,  10'd599,  1'b1, 9'd1,   8'd197, 8'd237, 8'd255},
      '{3'd1, 10'd1016, 10'd0,    1'b1, 9'd0,   8'd0,   8'd0,   8'd0},
      '{3'd2, 10'd0,    10'd0,    1'b0, 9'd0,   8'd0,   8'd0,   8'd0},
      '{3'd2, 10'd792,  10'd1023, 1'b0, 9'd0,   8'd0,   8'd0,   8'd0},
      '{3'd2, 10'd799,  10'd1023, 1'b0, 9'd0,   8'd0,   8'd0,   8'd0},
      '{3'd3, 10'd0,    10'd0,    1'b1, 9'd256, 8'd0,   8'd0,   8'd0},
      '{3'd3, 10'd504,  10'd1023, 1'b1, 9'd256, 8'd0,   8'd0,   8'd0},
      '{3'd4, 10'd0,    10'd300,  1'b0, 9'd0,   8'd0,   8'd0,   8'd0},
      '{3'd4, 10'd8,    10'd0,    1'b0, 9'd0,   8'd0,   8'd0,   8'd0},
      '{3'd5, 10'd0,    10'd0,    1'b0, 9'd0,   8'd0,   8'd0,   8'd0}
    };

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idle_pct  = 23;
    stall_pct = 23;
    cur_view  = 0;
    foreach (dir_tab[i]) begin
      if (dir_tab[i].view != cur_view) begin
        settle_block();
        cur_view = dir_tab[i].view;
        write_view(view_tab[cur_view]);
      end
      offer_group(dir_tab[i].col, dir_tab[i].row);
      if (dir_tab[i].typed) begin
        for (l = 0; l < NLANES; l++) begin
          col = dir_tab[i].col + l;
          if (col < IMAGE_W) begin
            px.column = COL_W'(col);
            px.count  = dir_tab[i].cnt;
            px.red    = dir_tab[i].red;
            px.green  = dir_tab[i].green;
            px.blue   = dir_tab[i].blue;
            px.last   = (col == IMAGE_W - 1) || (l == NLANES - 1);
            pixel_expect_q.push_back(px);
          end
        end
      end else begin
        predict_group(dir_tab[i].col, dir_tab[i].row);
      end
    end

    for (ph = 0; ph < 4; ph++) begin
      for (k = 0; k < 2; k++) begin
        settle_block();
        idle_pct  = idle_tab[ph];
        stall_pct = stall_tab[ph];
        if ($urandom_range(0, 3) == 0) begin
          vw = {$urandom, $urandom, $urandom, $urandom};
        end else begin
          sh    = $urandom_range(9, 31);
          vw.sx = ($urandom >> sh) | ($urandom & 32'h8000_0000);
          sh    = $urandom_range(9, 31);
          vw.sy = ($urandom >> sh) | ($urandom & 32'h8000_0000);
          vw.vx = $urandom_range(0, 32'h3000_0000) - 32'h2800_0000;
          vw.vy = $urandom_range(0, 32'h3000_0000) - 32'h1800_0000;
        end
        write_view(vw);
        if (ph == 0 && k == 0) hold_req = HOLD_CYCLES;
        for (n = 0; n < 50; n++) begin
          if ($urandom_range(0, 99) < 85) begin
            rc = COL_W'($urandom_range(0, IMAGE_W / NLANES - 1) * NLANES);
            rr = ROW_W'($urandom_range(0, 599));
          end else begin
            rc = COL_W'($urandom);
            rr = ROW_W'($urandom);
          end
          offer_group(rc, rr);
          predict_group(rc, rr);
        end
      end
    end

    settle_block();
    if (pixel_expect_q.size() != 0) begin
      $error("%0d expected pixel items never arrived", pixel_expect_q.size());
      err_cnt++;
    end
    $display("Covered %0d groups over %0d register views, %0d pixel items checked.",
             groups_sent, views_used, pixels_checked);
    $display("Phases: directed extremes, no idling, sender gaps, receiver stalls, both.");
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
